// File: hw/rtl/ptst_pkg.sv
// package: widths, codes and constants of the per-topic sample/throttle filter
package ptst_pkg;

  localparam int unsigned TOPIC_COUNT_DEF = 64;

  localparam int unsigned TOPIC_W   = 6;
  localparam int unsigned PAYLOAD_W = 32;
  localparam int unsigned TIME_W    = 48;
  localparam int unsigned COUNT_W   = 32;

  localparam int unsigned MODE_W     = 3;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned RATE_W     = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned TICK_W     = 4;
  localparam int unsigned TICK_WRAP  = 10;
  localparam int unsigned MS_PER_SEC = 1000;

  localparam int unsigned INTERVAL_RST = 100;
  localparam int unsigned RATE_RST     = 10;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE        = 3'd0,
    MODE_BUFFER      = 3'd1,
    MODE_DROP_OLDEST = 3'd2,
    MODE_DROP_NEWEST = 3'd3,
    MODE_SAMPLE      = 3'd4,
    MODE_THROTTLE    = 3'd5
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE     = 2'd0,
    CFG_INTERVAL = 2'd1,
    CFG_RATE     = 2'd2
  } cfg_idx_t;

endpackage

// File: hw/rtl/ptst_if.sv
// interfaces: message input channel and filter result channel
interface ptst_msg_if
  import ptst_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [TOPIC_W-1:0]   topic_id;
  logic [PAYLOAD_W-1:0] payload;
  logic [TIME_W-1:0]    now_ms;

  modport source (output valid, topic_id, payload, now_ms, input ready);
  modport sink   (input valid, topic_id, payload, now_ms, output ready);
endinterface

interface ptst_res_if
  import ptst_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic                 delivered;
  logic [TOPIC_W-1:0]   out_topic_id;
  logic [PAYLOAD_W-1:0] out_payload;
  logic [COUNT_W-1:0]   received_total;
  logic [COUNT_W-1:0]   dropped_total;
  logic [COUNT_W-1:0]   delivered_total;

  modport source (output valid, delivered, out_topic_id, out_payload, received_total,
                  dropped_total, delivered_total, input ready);
  modport sink   (input valid, delivered, out_topic_id, out_payload, received_total,
                  dropped_total, delivered_total, output ready);
endinterface

// File: hw/rtl/per_topic_sample_throttle_filter.sv
// top level: per-topic sample / throttle message filter
//
//   channel  | dir | handshake     | contents
//   msg      | in  | valid/ready   | topic_id, payload, now_ms
//   res      | out | valid/ready   | delivered, out_topic_id, out_payload, counters
//   cfg      | in  | cfg_we        | cfg_index, cfg_data (mode, interval, rate)
//
// one transaction per cycle unless res stalls; msg -> compute stage reg -> res reg
// per-topic tables: read at acceptance, written when the stage fires, with bypass
// reset clears control state and per-topic valid bits at once; no clearing pass
// a stalled res holds the compute stage, which then holds msg
module per_topic_sample_throttle_filter
  import ptst_pkg::*;
#(
  parameter int unsigned TOPIC_COUNT = TOPIC_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  ptst_msg_if.sink              msg,
  ptst_res_if.source            res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned SLOT_W = (TOPIC_COUNT > 1) ? $clog2(TOPIC_COUNT) : 1;
  localparam int unsigned SAMP_W = TICK_W + TIME_W;
  localparam int unsigned PROD_W = RATE_W + RATE_W + 1;

  // configuration
  mode_t                 mode;
  logic [INTERVAL_W-1:0] sample_interval_ms;
  logic [RATE_W-1:0]     throttle_rate;
  logic                  cfg_hit;

  assign cfg_hit = cfg_we && (cfg_index == CFG_MODE || cfg_index == CFG_INTERVAL ||
                              cfg_index == CFG_RATE);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode               <= MODE_BUFFER;
      sample_interval_ms <= INTERVAL_W'(INTERVAL_RST);
      throttle_rate      <= RATE_W'(RATE_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:     mode               <= mode_t'(cfg_data[MODE_W-1:0]);
        CFG_INTERVAL: sample_interval_ms <= cfg_data[INTERVAL_W-1:0];
        CFG_RATE:     throttle_rate      <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // topic to table slot
  logic [SLOT_W-1:0] in_slot;

  always_comb begin
    in_slot = '0;
    for (int i = 0; i < (1 << TOPIC_W); i++) begin
      if (msg.topic_id == TOPIC_W'(i)) begin
        in_slot = SLOT_W'(i % TOPIC_COUNT);
      end
    end
  end

  // handshake
  logic a_valid;
  logic advance;
  logic msg_accept;

  assign advance    = !res.valid || res.ready;
  assign msg.ready  = !a_valid || advance;
  assign msg_accept = msg.valid && msg.ready;

  // compute stage registers
  logic [TOPIC_W-1:0]   a_topic;
  logic [SLOT_W-1:0]    a_slot;
  logic [PAYLOAD_W-1:0] a_payload;
  logic [TIME_W-1:0]    a_now;
  logic [SAMP_W-1:0]    samp_rd;
  logic [TIME_W-1:0]    dlv_rd;

  // per-topic tables
  logic [SAMP_W-1:0]      samp_mem [TOPIC_COUNT];
  logic [TIME_W-1:0]      dlv_mem  [TOPIC_COUNT];
  logic [TOPIC_COUNT-1:0] samp_vld;
  logic [TOPIC_COUNT-1:0] dlv_vld;

  logic              samp_we;
  logic [SAMP_W-1:0] samp_wdata;
  logic              dlv_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (msg_accept) begin
      a_valid <= 1'b1;
    end else if (advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (msg_accept) begin
      a_topic   <= msg.topic_id;
      a_slot    <= in_slot;
      a_payload <= msg.payload;
      a_now     <= msg.now_ms;
      samp_rd   <= (samp_we && a_slot == in_slot) ? samp_wdata : samp_mem[in_slot];
      dlv_rd    <= (dlv_we && a_slot == in_slot) ? a_now : dlv_mem[in_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (samp_we) begin
      samp_mem[a_slot] <= samp_wdata;
    end
    if (dlv_we) begin
      dlv_mem[a_slot] <= a_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samp_vld <= '0;
      dlv_vld  <= '0;
    end else begin
      if (cfg_hit) begin
        samp_vld <= '0;
      end else if (samp_we) begin
        samp_vld[a_slot] <= 1'b1;
      end
      if (dlv_we) begin
        dlv_vld[a_slot] <= 1'b1;
      end
    end
  end

  // sample decision
  logic [TIME_W-1:0] samp_last;
  logic [TICK_W-1:0] tick;
  logic [TICK_W-1:0] tick_inc;
  logic [TICK_W-1:0] tick_next;
  logic [TIME_W-1:0] samp_diff;
  logic              samp_ok;

  assign samp_last = samp_vld[a_slot] ? samp_rd[TIME_W-1:0] : '0;
  assign tick      = samp_vld[a_slot] ? samp_rd[SAMP_W-1:TIME_W] : '0;
  assign tick_inc  = tick + TICK_W'(1);
  assign tick_next = (tick_inc >= TICK_W'(TICK_WRAP)) ? '0 : tick_inc;
  assign samp_diff = a_now - samp_last;
  assign samp_ok   = (a_now >= samp_last) &&
                     (samp_diff >= {{(TIME_W - INTERVAL_W){1'b0}}, sample_interval_ms});

  // throttle decision: floor(1000 / r) <= d  <=>  (d + 1) * r > 1000
  logic [TIME_W-1:0] dlv_last;
  logic [TIME_W-1:0] dlv_diff;
  logic [RATE_W-1:0] rate_eff;
  logic [PROD_W-1:0] thr_prod;
  logic              thr_far;
  logic              thr_ok;

  assign dlv_last = dlv_vld[a_slot] ? dlv_rd : '0;
  assign dlv_diff = a_now - dlv_last;
  assign rate_eff = (throttle_rate == '0) ? RATE_W'(1) : throttle_rate;
  assign thr_far  = dlv_diff >= TIME_W'(MS_PER_SEC);
  assign thr_prod = (PROD_W'(dlv_diff[RATE_W-1:0]) + PROD_W'(1)) * PROD_W'(rate_eff);
  assign thr_ok   = (a_now >= dlv_last) && (thr_far || thr_prod > PROD_W'(MS_PER_SEC));

  logic pass;
  logic drop;

  always_comb begin
    pass = 1'b0;
    drop = 1'b0;
    case (mode)
      MODE_NONE, MODE_BUFFER, MODE_DROP_OLDEST, MODE_DROP_NEWEST: pass = 1'b1;
      MODE_SAMPLE: begin
        pass = samp_ok || (tick_next == '0);
        drop = !pass;
      end
      MODE_THROTTLE: begin
        pass = thr_ok;
        drop = !thr_ok;
      end
      default: ;
    endcase
  end

  logic a_fire;

  assign a_fire     = a_valid && advance;
  assign samp_we    = a_fire && mode == MODE_SAMPLE;
  assign samp_wdata = samp_ok ? {tick, a_now} : {tick_next, samp_last};
  assign dlv_we     = a_fire && mode == MODE_THROTTLE && thr_ok;

  // counters and result register
  logic [COUNT_W-1:0] recv_cnt;
  logic [COUNT_W-1:0] drop_cnt;
  logic [COUNT_W-1:0] dlvd_cnt;
  logic [COUNT_W-1:0] recv_cnt_next;
  logic [COUNT_W-1:0] drop_cnt_next;
  logic [COUNT_W-1:0] dlvd_cnt_next;

  assign recv_cnt_next = recv_cnt + COUNT_W'(1);
  assign drop_cnt_next = drop_cnt + COUNT_W'(drop);
  assign dlvd_cnt_next = dlvd_cnt + COUNT_W'(pass);

  always_ff @(posedge clk) begin
    if (rst) begin
      recv_cnt  <= '0;
      drop_cnt  <= '0;
      dlvd_cnt  <= '0;
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= a_valid;
      if (a_valid) begin
        recv_cnt <= recv_cnt_next;
        drop_cnt <= drop_cnt_next;
        dlvd_cnt <= dlvd_cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      res.delivered       <= pass;
      res.out_topic_id    <= a_topic;
      res.out_payload     <= a_payload;
      res.received_total  <= recv_cnt_next;
      res.dropped_total   <= drop_cnt_next;
      res.delivered_total <= dlvd_cnt_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_recv_step: assert property (@(posedge clk) disable iff (rst)
    a_fire |=> res.received_total == $past(recv_cnt_next))
    else $error("received counter out of step");

  a_pass_modes: assert property (@(posedge clk) disable iff (rst)
    a_fire && (mode == MODE_NONE || mode == MODE_BUFFER || mode == MODE_DROP_OLDEST ||
               mode == MODE_DROP_NEWEST) |=> res.delivered)
    else $error("pass-through mode dropped a transaction");

  a_count_split: assert property (@(posedge clk) disable iff (rst)
    a_fire && (mode == MODE_SAMPLE || mode == MODE_THROTTLE) |->
      (drop_cnt_next + dlvd_cnt_next) == (drop_cnt + dlvd_cnt + COUNT_W'(1)))
    else $error("filtered transaction not counted exactly once");

  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> samp_vld == '0)
    else $error("sample table not cleared on config write");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    a_valid && !advance |=> a_valid && $stable(a_slot) && $stable(samp_rd))
    else $error("compute stage lost data under stall");
`endif

endmodule
